// File: hw/rtl/spb_pkg.sv
// Shared types, constants and helper functions of the spatial pixel binning block.
// Used by the channel interfaces, the divider and the top level. No dependencies.
package spb_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int MAX_BIN      = 16;
  localparam int PIXEL_BITS   = 16;

  localparam int SIZE_BITS  = 13;                      // frame size registers
  localparam int POS_BITS   = $clog2(MAX_WIDTH);       // column, row and line address
  localparam int BIN_BITS   = 5;                       // bin size registers
  localparam int SUB_BITS   = $clog2(MAX_BIN);         // position inside a bin
  localparam int AREA_BITS  = $clog2(MAX_BIN * MAX_BIN) + 1;
  localparam int ACC_BITS   = 24;                      // horizontal and line sums
  localparam int VALUE_BITS = 16;                      // result and max_value width
  localparam int IDX_BITS   = 3;
  localparam int DATA_BITS  = 16;

  localparam int DIV_STEPS    = ACC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef enum logic [IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_BIN_WIDTH    = 3'd2,
    CFG_BIN_HEIGHT   = 3'd3,
    CFG_BIN_MODE     = 3'd4,
    CFG_MAX_VALUE    = 3'd5
  } spb_cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_MEAN = 3'd0,
    MODE_SUM  = 3'd1,
    MODE_MIN  = 3'd2,
    MODE_MAX  = 3'd3,
    MODE_SKIP = 3'd4
  } spb_mode_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MEAN,
    ST_CFG,
    ST_DIV_W,
    ST_DIV_H,
    ST_DIV_C,
    ST_DIV_R
  } spb_state_t;

  typedef struct packed {
    logic                 start;
    logic [ACC_BITS-1:0]  num;
    logic [AREA_BITS-1:0] den;
  } spb_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [ACC_BITS-1:0]  quo;
    logic [AREA_BITS-1:0] rem;
  } spb_div_res_t;

  // Frame size limited to 1..limit.
  function automatic logic [SIZE_BITS-1:0] sat_size(input logic [SIZE_BITS-1:0] v,
                                                    input logic [SIZE_BITS-1:0] limit);
    logic [SIZE_BITS-1:0] r;
    if (v == '0) begin
      r = SIZE_BITS'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Bin size limited to 1..MAX_BIN.
  function automatic logic [BIN_BITS-1:0] sat_bin(input logic [BIN_BITS-1:0] v);
    logic [BIN_BITS-1:0] r;
    if (v == '0) begin
      r = BIN_BITS'(1);
    end else if (v > BIN_BITS'(MAX_BIN)) begin
      r = BIN_BITS'(MAX_BIN);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Combines a running value with a new one; skip keeps the running value.
  function automatic logic [ACC_BITS-1:0] merge(input spb_mode_t mode,
                                                input logic [ACC_BITS-1:0] acc,
                                                input logic [ACC_BITS-1:0] p);
    logic [ACC_BITS-1:0] r;
    unique case (mode)
      MODE_MEAN, MODE_SUM: r = acc + p;
      MODE_MIN:            r = (p < acc) ? p : acc;
      MODE_MAX:            r = (p > acc) ? p : acc;
      default:             r = acc;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/spb_channels.sv
// Valid/ready channel interfaces of the pixel binning block: input, result and configuration.
// Depends on spb_pkg for the field widths.

interface spb_in_if;
  logic                            valid;
  logic                            ready;
  logic [spb_pkg::PIXEL_BITS-1:0]  pixel;
  logic                            frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface spb_out_if;
  logic                            valid;
  logic                            ready;
  logic [spb_pkg::VALUE_BITS-1:0]  binned_value;
  logic                            row_end;
  logic                            frame_end;

  modport source (output valid, output binned_value, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input binned_value, input row_end, input frame_end,
                  output ready);
endinterface

interface spb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spb_pkg::IDX_BITS-1:0]    index;
  logic [spb_pkg::DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/spb_div.sv
// Restoring divider, one quotient bit per cycle, shared by the mean and the size recalculation.
// Depends on spb_pkg for the request and result structs.
module spb_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spb_pkg::spb_div_req_t req,
  output spb_pkg::spb_div_res_t res
);

  logic [spb_pkg::ACC_BITS-1:0]     quo_r;
  logic [spb_pkg::AREA_BITS-1:0]    rem_r;
  logic [spb_pkg::AREA_BITS-1:0]    den_r;
  logic [spb_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;

  logic [spb_pkg::AREA_BITS:0]      trial;
  logic                             ge;
  logic [spb_pkg::AREA_BITS-1:0]    rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[spb_pkg::ACC_BITS-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? spb_pkg::AREA_BITS'(trial - {1'b0, den_r})
                 : trial[spb_pkg::AREA_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == spb_pkg::DIV_CNT_BITS'(spb_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      quo_r <= {quo_r[spb_pkg::ACC_BITS-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

// File: hw/rtl/spatial_pixel_binning_core.sv
// Spatial pixel binning: reduces each bin_width x bin_height block of a raster stream to one item.
// Depends on spb_pkg, the channel interfaces in spb_channels.sv and the divider spb_div.
// Throughput: one item per cycle, except that the input is held while a result is queued or about
// to be, and during a mean division. Each configuration write starts a recalculation in the shared
// divider, during which no item is taken. Reset (rst_n, synchronous, active low) restores the
// register defaults and position zero; the line store keeps no reset and is filled by the first
// bin row.
module spatial_pixel_binning_core (
  input  logic        clk,
  input  logic        rst_n,
  spb_in_if.sink      in_chan,
  spb_out_if.source   out_chan,
  spb_cfg_if.sink     cfg_chan
);

  // ---------------------------------------------------------------------------------------------
  // Configuration registers. They are kept as written; limits are applied where they are used.
  // ---------------------------------------------------------------------------------------------
  logic [spb_pkg::SIZE_BITS-1:0]  frame_width_r;
  logic [spb_pkg::SIZE_BITS-1:0]  frame_height_r;
  logic [spb_pkg::BIN_BITS-1:0]   bin_width_r;
  logic [spb_pkg::BIN_BITS-1:0]   bin_height_r;
  spb_pkg::spb_mode_t             bin_mode_r;
  logic [spb_pkg::VALUE_BITS-1:0] max_value_r;

  logic cfg_wr;
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr = cfg_chan.valid && cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= spb_pkg::SIZE_BITS'(spb_pkg::MAX_WIDTH);
      frame_height_r <= spb_pkg::SIZE_BITS'(spb_pkg::HEIGHT_LIMIT);
      bin_width_r    <= spb_pkg::BIN_BITS'(1);
      bin_height_r   <= spb_pkg::BIN_BITS'(1);
      bin_mode_r     <= spb_pkg::MODE_MEAN;
      max_value_r    <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_chan.index)
        spb_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_chan.data[spb_pkg::SIZE_BITS-1:0];
        spb_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_chan.data[spb_pkg::SIZE_BITS-1:0];
        spb_pkg::CFG_BIN_WIDTH:    bin_width_r    <= cfg_chan.data[spb_pkg::BIN_BITS-1:0];
        spb_pkg::CFG_BIN_HEIGHT:   bin_height_r   <= cfg_chan.data[spb_pkg::BIN_BITS-1:0];
        spb_pkg::CFG_BIN_MODE: begin
          // Codes above skip are not modes; the register keeps what it had.
          if (cfg_chan.data[2:0] <= spb_pkg::MODE_SKIP) begin
            bin_mode_r <= spb_pkg::spb_mode_t'(cfg_chan.data[2:0]);
          end
        end
        spb_pkg::CFG_MAX_VALUE:    max_value_r    <= cfg_chan.data[spb_pkg::VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Limited sizes, the mean divisor and the pixel ceiling.
  logic [spb_pkg::SIZE_BITS-1:0]  w_s;
  logic [spb_pkg::SIZE_BITS-1:0]  h_s;
  logic [spb_pkg::BIN_BITS-1:0]   bw_s;
  logic [spb_pkg::BIN_BITS-1:0]   bh_s;
  logic [spb_pkg::AREA_BITS-1:0]  area;
  logic [spb_pkg::PIXEL_BITS-1:0] maxv;

  always_comb begin
    w_s  = spb_pkg::sat_size(frame_width_r, spb_pkg::SIZE_BITS'(spb_pkg::MAX_WIDTH));
    h_s  = spb_pkg::sat_size(frame_height_r, spb_pkg::SIZE_BITS'(spb_pkg::HEIGHT_LIMIT));
    bw_s = spb_pkg::sat_bin(bin_width_r);
    bh_s = spb_pkg::sat_bin(bin_height_r);
    area = spb_pkg::AREA_BITS'(bw_s * bh_s);
    maxv = spb_pkg::PIXEL_BITS'(max_value_r);
  end

  // ---------------------------------------------------------------------------------------------
  // Position state. Besides the raw column and row, the block keeps the position inside the bin
  // (xin, yin) and the bin index (ox, oy), and the output frame size (ow, oh). These follow the
  // column and row incrementally; after a configuration write the sequencer recomputes them in
  // the shared divider so that, once it is done, they equal col % bw, col / bw and so on.
  // ---------------------------------------------------------------------------------------------
  logic [spb_pkg::POS_BITS-1:0]  col_r, row_r, ox_r, oy_r;
  logic [spb_pkg::SUB_BITS-1:0]  xin_r, yin_r;
  logic [spb_pkg::SIZE_BITS-1:0] ow_r, oh_r;
  logic [spb_pkg::ACC_BITS-1:0]  hacc_r;

  spb_pkg::spb_state_t state_r, state_nxt;
  spb_pkg::spb_div_req_t div_req;
  spb_pkg::spb_div_res_t div_res;

  // Second stage (line store read-modify-write) and result holding registers.
  logic                          s1_v_r, s1_pass_r, s1_first_r, s1_last_r, s1_re_r, s1_fe_r;
  logic [spb_pkg::POS_BITS-1:0]  s1_addr_r;
  logic [spb_pkg::ACC_BITS-1:0]  s1_data_r;
  logic                          res_pend_r, res_re_r, res_fe_r;
  logic [spb_pkg::VALUE_BITS-1:0] res_val_r;
  logic                          out_valid_r, out_re_r, out_fe_r;
  logic [spb_pkg::VALUE_BITS-1:0] out_val_r;

  // ---------------------------------------------------------------------------------------------
  // First stage: position decode and horizontal reduction at the accepting edge.
  // ---------------------------------------------------------------------------------------------
  logic                          s1_res, s1_mean;
  logic                          in_acc;
  logic [spb_pkg::PIXEL_BITS-1:0] p;
  logic [spb_pkg::ACC_BITS-1:0]  p_ext, hacc_first, hacc_new;
  logic [spb_pkg::POS_BITS-1:0]  col_e, row_e, ox_e, oy_e;
  logic [spb_pkg::SUB_BITS-1:0]  xin_e, yin_e;
  logic                          pass, in_area, col_last, row_last, x_last, y_last;
  logic                          line_op, s1_load;
  logic [spb_pkg::POS_BITS-1:0]  col_nxt, row_nxt, ox_nxt, oy_nxt;
  logic [spb_pkg::SUB_BITS-1:0]  xin_nxt, yin_nxt;

  // An item is taken only in normal running, and not while a result is queued or about to be.
  assign in_chan.ready = (state_r == spb_pkg::ST_RUN) && !res_pend_r && !s1_res;
  assign in_acc = in_chan.valid && in_chan.ready;

  always_comb begin
    p     = in_chan.pixel;
    p_ext = spb_pkg::ACC_BITS'(p);
    // A frame start puts this item at column zero of row zero.
    col_e = in_chan.frame_start ? '0 : col_r;
    row_e = in_chan.frame_start ? '0 : row_r;
    ox_e  = in_chan.frame_start ? '0 : ox_r;
    oy_e  = in_chan.frame_start ? '0 : oy_r;
    xin_e = in_chan.frame_start ? '0 : xin_r;
    yin_e = in_chan.frame_start ? '0 : yin_r;

    pass     = ((bw_s == spb_pkg::BIN_BITS'(1)) && (bh_s == spb_pkg::BIN_BITS'(1))) ||
               (ow_r == '0) || (oh_r == '0);
    in_area  = ({1'b0, ox_e} < ow_r) && ({1'b0, oy_e} < oh_r);
    col_last = ({1'b0, col_e} + 1'b1) >= w_s;
    row_last = ({1'b0, row_e} + 1'b1) >= h_s;
    x_last   = {1'b0, xin_e} == (bw_s - 1'b1);
    y_last   = {1'b0, yin_e} == (bh_s - 1'b1);

    // Minimum starts from the ceiling, so the first pixel is already limited by it.
    if ((bin_mode_r == spb_pkg::MODE_MIN) && (p > maxv)) begin
      hacc_first = spb_pkg::ACC_BITS'(maxv);
    end else begin
      hacc_first = p_ext;
    end
    hacc_new = (xin_e == '0) ? hacc_first : spb_pkg::merge(bin_mode_r, hacc_r, p_ext);

    line_op = !pass && in_area && x_last;
    s1_load = pass || line_op;

    // Position advance; every item moves the position, dropped or not.
    if (col_last) begin
      col_nxt = '0;
      xin_nxt = '0;
      ox_nxt  = '0;
      if (row_last) begin
        row_nxt = '0;
        yin_nxt = '0;
        oy_nxt  = '0;
      end else begin
        row_nxt = row_e + 1'b1;
        if (y_last) begin
          yin_nxt = '0;
          oy_nxt  = oy_e + 1'b1;
        end else begin
          yin_nxt = yin_e + 1'b1;
          oy_nxt  = oy_e;
        end
      end
    end else begin
      col_nxt = col_e + 1'b1;
      row_nxt = row_e;
      yin_nxt = yin_e;
      oy_nxt  = oy_e;
      if (x_last) begin
        xin_nxt = '0;
        ox_nxt  = ox_e + 1'b1;
      end else begin
        xin_nxt = xin_e + 1'b1;
        ox_nxt  = ox_e;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Line store: one partial column result per output column. Read at the accepting edge, merged
  // and written back in the next cycle. A write in the cycle before is not yet seen by the read,
  // so the last written entry is kept and forwarded when the addresses match.
  // ---------------------------------------------------------------------------------------------
  logic [spb_pkg::ACC_BITS-1:0] line_mem [spb_pkg::MAX_WIDTH];
  logic [spb_pkg::ACC_BITS-1:0] rd_data_r;
  logic                         lw_v_r;
  logic [spb_pkg::POS_BITS-1:0] lw_addr_r;
  logic [spb_pkg::ACC_BITS-1:0] lw_data_r;
  logic [spb_pkg::ACC_BITS-1:0] line_old, line_new;
  logic                         mem_we;
  logic [spb_pkg::VALUE_BITS-1:0] s1_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_addr_r] <= line_new;
    end
    if (in_acc && line_op) begin
      rd_data_r <= line_mem[ox_e];
    end
  end

  always_comb begin
    line_old = (lw_v_r && (lw_addr_r == s1_addr_r)) ? lw_data_r : rd_data_r;
    line_new = s1_first_r ? s1_data_r : spb_pkg::merge(bin_mode_r, line_old, s1_data_r);
    mem_we   = s1_v_r && !s1_pass_r;
    s1_res   = s1_v_r && (s1_pass_r || s1_last_r);
    s1_mean  = s1_res && !s1_pass_r && (bin_mode_r == spb_pkg::MODE_MEAN);

    // Pass-through items are sent unchanged; sums are limited; min, max and skip are not.
    if (s1_pass_r) begin
      s1_val = s1_data_r[spb_pkg::VALUE_BITS-1:0];
    end else if ((bin_mode_r == spb_pkg::MODE_SUM) &&
                 (line_new > spb_pkg::ACC_BITS'(maxv))) begin
      s1_val = spb_pkg::VALUE_BITS'(maxv);
    end else begin
      s1_val = line_new[spb_pkg::VALUE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Sequencer: normal running, the mean division, and the recalculation after a write.
  // ---------------------------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    if (cfg_wr) begin
      // The new register value is visible in the next cycle, so the recalculation waits in ST_CFG.
      state_nxt = spb_pkg::ST_CFG;
    end else begin
      unique case (state_r)
        spb_pkg::ST_RUN:   if (s1_mean) state_nxt = spb_pkg::ST_MEAN;
        spb_pkg::ST_MEAN:  if (div_res.done) state_nxt = spb_pkg::ST_RUN;
        spb_pkg::ST_CFG:   state_nxt = spb_pkg::ST_DIV_W;
        spb_pkg::ST_DIV_W: if (div_res.done) state_nxt = spb_pkg::ST_DIV_H;
        spb_pkg::ST_DIV_H: if (div_res.done) state_nxt = spb_pkg::ST_DIV_C;
        spb_pkg::ST_DIV_C: if (div_res.done) state_nxt = spb_pkg::ST_DIV_R;
        spb_pkg::ST_DIV_R: if (div_res.done) state_nxt = spb_pkg::ST_RUN;
        default:           state_nxt = spb_pkg::ST_RUN;
      endcase
    end
  end

  // The divider is started on entry to each dividing state with the operands of that state.
  always_comb begin
    div_req.start = (state_nxt != state_r) && (state_nxt != spb_pkg::ST_RUN) &&
                    (state_nxt != spb_pkg::ST_CFG);
    div_req.num   = '0;
    div_req.den   = spb_pkg::AREA_BITS'(1);
    unique case (state_nxt)
      spb_pkg::ST_MEAN: begin
        div_req.num = line_new;
        div_req.den = area;
      end
      spb_pkg::ST_DIV_W: begin
        div_req.num = spb_pkg::ACC_BITS'(w_s);
        div_req.den = spb_pkg::AREA_BITS'(bw_s);
      end
      spb_pkg::ST_DIV_H: begin
        div_req.num = spb_pkg::ACC_BITS'(h_s);
        div_req.den = spb_pkg::AREA_BITS'(bh_s);
      end
      spb_pkg::ST_DIV_C: begin
        div_req.num = spb_pkg::ACC_BITS'(col_r);
        div_req.den = spb_pkg::AREA_BITS'(bw_s);
      end
      spb_pkg::ST_DIV_R: begin
        div_req.num = spb_pkg::ACC_BITS'(row_r);
        div_req.den = spb_pkg::AREA_BITS'(bh_s);
      end
      default: ;
    endcase
  end

  spb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spb_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Position registers: advanced by items, overwritten by the recalculation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      xin_r  <= '0;
      yin_r  <= '0;
      hacc_r <= '0;
      ow_r   <= spb_pkg::SIZE_BITS'(spb_pkg::MAX_WIDTH);
      oh_r   <= spb_pkg::SIZE_BITS'(spb_pkg::HEIGHT_LIMIT);
    end else begin
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        ox_r  <= ox_nxt;
        oy_r  <= oy_nxt;
        xin_r <= xin_nxt;
        yin_r <= yin_nxt;
        if (!pass && in_area) begin
          hacc_r <= hacc_new;
        end
      end
      if (div_res.done) begin
        unique case (state_r)
          spb_pkg::ST_DIV_W: ow_r <= div_res.quo[spb_pkg::SIZE_BITS-1:0];
          spb_pkg::ST_DIV_H: oh_r <= div_res.quo[spb_pkg::SIZE_BITS-1:0];
          spb_pkg::ST_DIV_C: begin
            ox_r  <= div_res.quo[spb_pkg::POS_BITS-1:0];
            xin_r <= div_res.rem[spb_pkg::SUB_BITS-1:0];
          end
          spb_pkg::ST_DIV_R: begin
            oy_r  <= div_res.quo[spb_pkg::POS_BITS-1:0];
            yin_r <= div_res.rem[spb_pkg::SUB_BITS-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // Second stage control and the forwarding record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      lw_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc && s1_load;
      lw_v_r <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pass_r  <= pass;
      s1_first_r <= (yin_e == '0);
      s1_last_r  <= y_last;
      s1_addr_r  <= ox_e;
      s1_data_r  <= pass ? p_ext : hacc_new;
      if (pass) begin
        s1_re_r <= col_last;
        s1_fe_r <= col_last && row_last;
      end else begin
        s1_re_r <= ({1'b0, ox_e} == (ow_r - 1'b1));
        s1_fe_r <= ({1'b0, ox_e} == (ow_r - 1'b1)) && ({1'b0, oy_e} == (oh_r - 1'b1));
      end
    end
    if (mem_we) begin
      lw_addr_r <= s1_addr_r;
      lw_data_r <= line_new;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Result queue of one entry in front of the output register, so that a result waiting at the
  // output does not hold up the input.
  // ---------------------------------------------------------------------------------------------
  logic res_set, res_take, mean_done;

  always_comb begin
    mean_done = (state_r == spb_pkg::ST_MEAN) && div_res.done;
    res_set   = (s1_res && !s1_mean) || mean_done;
    res_take  = res_pend_r && (!out_valid_r || out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_set) begin
        res_pend_r <= 1'b1;
      end else if (res_take) begin
        res_pend_r <= 1'b0;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mean_done) begin
      // The mean is limited to the ceiling after the division.
      if (div_res.quo > spb_pkg::ACC_BITS'(maxv)) begin
        res_val_r <= spb_pkg::VALUE_BITS'(maxv);
      end else begin
        res_val_r <= div_res.quo[spb_pkg::VALUE_BITS-1:0];
      end
      res_re_r <= s1_re_r;
      res_fe_r <= s1_fe_r;
    end else if (res_set) begin
      res_val_r <= s1_val;
      res_re_r  <= s1_re_r;
      res_fe_r  <= s1_fe_r;
    end
    if (res_take) begin
      out_val_r <= res_val_r;
      out_re_r  <= res_re_r;
      out_fe_r  <= res_fe_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.binned_value = out_val_r;
  assign out_chan.row_end      = out_re_r;
  assign out_chan.frame_end    = out_fe_r;

endmodule
